// File: rtl/n2tf_pkg.sv
// shared types, constants and the seven-segment table for number_to_tm1637_frames
// no dependencies; imported by every module of the block
package n2tf_pkg;

  localparam int VALUE_W   = 14;
  localparam int BYTE_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int CFG_IDX_W = 8;

  // x / 10 for x below 2^16 as (x * 52429) >> 19
  localparam logic [15:0] RECIP       = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [BYTE_W-1:0] ADDR_BASE = 8'hC0;
  localparam logic [BYTE_W-1:0] BLANK     = 8'h00;

  localparam logic [BYTE_W-1:0] DATA_COMMAND_RST    = 8'h40;
  localparam logic [BYTE_W-1:0] DISPLAY_CONTROL_RST = 8'h8F;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_COMMAND    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_CONTROL = 8'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_command;
    logic [BYTE_W-1:0] display_control;
  } cfg_regs_t;

  function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [BYTE_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'b00111111;
      4'd1:    s = 8'b00000110;
      4'd2:    s = 8'b01011011;
      4'd3:    s = 8'b01001111;
      4'd4:    s = 8'b01100110;
      4'd5:    s = 8'b01101101;
      4'd6:    s = 8'b01111101;
      4'd7:    s = 8'b00000111;
      4'd8:    s = 8'b01111111;
      4'd9:    s = 8'b01101111;
      default: s = 8'b00000000;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/n2tf_digit_stage.sv
// one pipeline stage that peels off decimal digit K of the remaining quotient
// depends on n2tf_pkg
module n2tf_digit_stage import n2tf_pkg::*; #(
  parameter int DIGITS = 4,
  parameter int K      = 0,
  parameter int CNT_W  = $clog2(DIGITS + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [VALUE_W-1:0]        in_rem,
  input  logic [DIGITS*DIGIT_W-1:0] in_digits,
  input  logic [CNT_W-1:0]          in_count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [VALUE_W-1:0]        out_rem,
  output logic [DIGITS*DIGIT_W-1:0] out_digits,
  output logic [CNT_W-1:0]          out_count
);

  logic [VALUE_W+16-1:0]     prod;
  logic [VALUE_W-1:0]        quot;
  logic [VALUE_W-1:0]        times_ten;
  logic [DIGIT_W-1:0]        digit;
  logic [DIGITS*DIGIT_W-1:0] digits_next;

  always_comb begin
    prod      = (VALUE_W + 16)'(in_rem) * (VALUE_W + 16)'(RECIP);
    quot      = VALUE_W'(prod >> RECIP_SHIFT);
    times_ten = (quot << 3) + (quot << 1);
    digit     = DIGIT_W'(in_rem - times_ten);
    digits_next = in_digits;
    digits_next[K*DIGIT_W +: DIGIT_W] = digit;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_rem    <= quot;
      out_digits <= digits_next;
      // a digit counts while the quotient ahead of it is still nonzero
      out_count  <= in_count + CNT_W'(in_rem != '0);
    end
  end

endmodule

// File: rtl/n2tf_emitter.sv
// byte sequencer: walks the clear groups and digit groups of one item and
// drives the registered output stream; depends on n2tf_pkg
module n2tf_emitter import n2tf_pkg::*; #(
  parameter int DIGITS = 4,
  parameter int CNT_W  = $clog2(DIGITS + 1),
  parameter int POS_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_regs_t                 cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [DIGITS*DIGIT_W-1:0] in_digits,
  input  logic [CNT_W-1:0]          in_count,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [BYTE_W-1:0]         m_byte,
  output logic                      m_start,
  output logic                      m_end,
  output logic                      m_last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_DIGIT = 3'b100
  } emit_state_t;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

  emit_state_t               state;
  logic [POS_W-1:0]          pos;
  logic [1:0]                sub;
  logic [DIGITS*DIGIT_W-1:0] digits;
  logic [CNT_W-1:0]          count;

  logic              gen;
  logic              take;
  logic [BYTE_W-1:0] byte_val;
  logic              st_val;
  logic              en_val;
  logic              is_last;

  always_comb begin
    byte_val = BLANK;
    st_val   = 1'b0;
    en_val   = 1'b0;
    is_last  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        unique case (sub)
          2'd0: begin
            byte_val = cfg.data_command;
            st_val   = 1'b1;
            en_val   = 1'b1;
          end
          2'd1: begin
            byte_val = ADDR_BASE + BYTE_W'(pos);
            st_val   = 1'b1;
          end
          default: begin
            byte_val = BLANK;
            en_val   = 1'b1;
            is_last  = (pos == LAST_POS) && (count == '0);
          end
        endcase
      end
      ST_DIGIT: begin
        unique case (sub)
          2'd0: begin
            byte_val = cfg.data_command;
            st_val   = 1'b1;
            en_val   = 1'b1;
          end
          2'd1: begin
            // least significant digit goes to the rightmost position
            byte_val = ADDR_BASE + BYTE_W'(LAST_POS - pos);
            st_val   = 1'b1;
          end
          2'd2: begin
            byte_val = seg_code(digits[pos*DIGIT_W +: DIGIT_W]);
            en_val   = 1'b1;
          end
          default: begin
            byte_val = cfg.display_control;
            st_val   = 1'b1;
            en_val   = 1'b1;
            is_last  = (CNT_W'(pos) + CNT_W'(1)) == count;
          end
        endcase
      end
      default: begin
        byte_val = BLANK;
      end
    endcase
  end

  assign gen      = (state != ST_IDLE) && (!m_tvalid || m_tready);
  assign in_ready = (state == ST_IDLE) || (gen && is_last);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pos      <= '0;
      sub      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (gen) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (take) begin
        state <= ST_CLEAR;
        pos   <= '0;
        sub   <= '0;
      end else if (gen && is_last) begin
        state <= ST_IDLE;
      end else if (gen) begin
        unique case (state)
          ST_CLEAR: begin
            if (sub == 2'd2) begin
              sub <= '0;
              if (pos == LAST_POS) begin
                state <= ST_DIGIT;
                pos   <= '0;
              end else begin
                pos <= pos + POS_W'(1);
              end
            end else begin
              sub <= sub + 2'd1;
            end
          end
          ST_DIGIT: begin
            if (sub == 2'd3) begin
              sub <= '0;
              pos <= pos + POS_W'(1);
            end else begin
              sub <= sub + 2'd1;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      digits <= in_digits;
      count  <= in_count;
    end
    if (gen) begin
      m_byte  <= byte_val;
      m_start <= st_val;
      m_end   <= en_val;
      m_last  <= is_last;
    end
  end

endmodule

// File: rtl/number_to_tm1637_frames.sv
// top level: turns a number into the bus bytes for a four-digit tm1637-style display
// depends on n2tf_pkg, n2tf_digit_stage and n2tf_emitter
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata[13:0] value, [15:14] zero
//  m_*      | out       | m_tvalid/m_tready  | m_tdata bus_byte, m_tuser, m_tlast last
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data byte
//
// an item yields 3*DIGITS bytes of clear groups plus 4 bytes per significant
// digit, so 12 to 28 bytes at four digits, one byte per cycle while m_tready is high
// the byte sequencer sets the rate: a new item is taken in the cycle its
// predecessor's final byte is produced; the first byte passes the input
// register, the digit stages and the sequencer state to the output register
// rst clears all valid bits, the sequencer and the registers to 0x40 / 0x8f
// a stall on m_tready holds the output register and backs up the digit
// pipeline stage by stage; nothing is dropped or repeated
module number_to_tm1637_frames import n2tf_pkg::*; #(
  parameter int DIGITS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  // slave stream: [13:0] value, [15:14] zero
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,
  // master stream: [7:0] bus_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  // [0] frame_start, [1] frame_end
  output logic [1:0]           m_tuser,
  output logic                 m_tlast,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(DIGITS + 1);
  // largest value the display can hold
  localparam logic [31:0] LIMIT = 32'(10 ** DIGITS - 1);

  cfg_regs_t cfg;

  // register file, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_command    <= DATA_COMMAND_RST;
      cfg.display_control <= DISPLAY_CONTROL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DATA_COMMAND:    cfg.data_command    <= cfg_data;
        REG_DISPLAY_CONTROL: cfg.display_control <= cfg_data;
        default: begin
          // unknown index is ignored
        end
      endcase
    end
  end

  // stage signals: index k feeds digit stage k
  logic                      st_valid  [DIGITS+1];
  logic                      st_ready  [DIGITS+1];
  logic [VALUE_W-1:0]        st_rem    [DIGITS];
  logic [DIGITS*DIGIT_W-1:0] st_digits [DIGITS+1];
  logic [CNT_W-1:0]          st_count  [DIGITS+1];

  // input stage: capture and saturate
  logic [VALUE_W-1:0] in_value;
  logic [VALUE_W-1:0] sat_value;

  assign in_value  = s_tdata[VALUE_W-1:0];
  assign sat_value = (32'(in_value) > LIMIT) ? VALUE_W'(LIMIT) : in_value;
  assign s_tready  = !st_valid[0] || st_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (s_tready) begin
      st_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st_rem[0] <= sat_value;
    end
  end

  assign st_digits[0] = '0;
  assign st_count[0]  = '0;

  // one stage per decimal digit, least significant first
  for (genvar k = 0; k < DIGITS; k++) begin : g_digit
    if (k < DIGITS - 1) begin : g_mid
      n2tf_digit_stage #(
        .DIGITS (DIGITS),
        .K      (k)
      ) u_stage (
        .clk        (clk),
        .rst        (rst),
        .in_valid   (st_valid[k]),
        .in_ready   (st_ready[k]),
        .in_rem     (st_rem[k]),
        .in_digits  (st_digits[k]),
        .in_count   (st_count[k]),
        .out_valid  (st_valid[k+1]),
        .out_ready  (st_ready[k+1]),
        .out_rem    (st_rem[k+1]),
        .out_digits (st_digits[k+1]),
        .out_count  (st_count[k+1])
      );
    end else begin : g_end
      // the quotient after the top digit is not needed
      n2tf_digit_stage #(
        .DIGITS (DIGITS),
        .K      (k)
      ) u_stage (
        .clk        (clk),
        .rst        (rst),
        .in_valid   (st_valid[k]),
        .in_ready   (st_ready[k]),
        .in_rem     (st_rem[k]),
        .in_digits  (st_digits[k]),
        .in_count   (st_count[k]),
        .out_valid  (st_valid[k+1]),
        .out_ready  (st_ready[k+1]),
        .out_rem    (),
        .out_digits (st_digits[k+1]),
        .out_count  (st_count[k+1])
      );
    end
  end

  // byte sequencer with the output register
  n2tf_emitter #(
    .DIGITS (DIGITS)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (st_valid[DIGITS]),
    .in_ready  (st_ready[DIGITS]),
    .in_digits (st_digits[DIGITS]),
    .in_count  (st_count[DIGITS]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_byte    (m_tdata),
    .m_start   (m_tuser[0]),
    .m_end     (m_tuser[1]),
    .m_last    (m_tlast)
  );

endmodule

// File: rtl/n2tf_checker.sv
// port-level checks on the output stream of number_to_tm1637_frames
// depends on n2tf_pkg; attached to the top level by the bind at the end
module n2tf_checker import n2tf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [7:0]           m_tdata,
  input logic [1:0]           m_tuser,
  input logic                 m_tlast
);

  // set after an address byte (start without stop) has gone out
  logic addr_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_pending <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      addr_pending <= m_tuser[0] && !m_tuser[1];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1] && !addr_pending == m_tuser[0])
    else $error("final item of a value does not close a frame");

  a_data_after_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && addr_pending |-> m_tuser == 2'b10)
    else $error("address byte not followed by a data byte");

  a_frame_opens: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !addr_pending |-> m_tuser[0] && (m_tuser[1] || m_tdata[7:6] == 2'b11))
    else $error("byte outside a frame or bad address byte");

endmodule

bind number_to_tm1637_frames n2tf_checker u_n2tf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
